// ===== rtl/core/cht_pkg.sv =====
// Shared types, constants and the key mixing round for the coalesced hash table.
// No dependencies; every other file in this folder except cht_ram imports it.
package cht_pkg;

  localparam int SLOTS  = 64;
  localparam int AW     = $clog2(SLOTS);
  localparam int LW     = AW + 1;
  localparam int CNT_W  = AW + 1;
  localparam int FILL_W = 7;
  localparam int NUM_W  = 7;
  localparam int RND_W  = 3;
  localparam int CMP_W  = ((FILL_W > CNT_W) ? FILL_W : CNT_W) + 1;

  localparam logic [RND_W-1:0] ROUND_LAST = RND_W'(5);
  localparam logic [LW-1:0]    NO_LINK    = {LW{1'b1}};
  localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(48);

  localparam logic [1:0] FN_GET = 2'd0;
  localparam logic [1:0] FN_SET = 2'd1;
  localparam logic [1:0] FN_DEL = 2'd2;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]    func;
    logic [31:0]   key;
    logic [31:0]   value;
    logic [AW-1:0] home;
  } cht_req_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } cht_stat_t;

  function automatic logic [31:0] cht_round(input logic [31:0] a, input logic [RND_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      RND_W'(0): r = (a + 32'h7ed55d16) + (a << 12);
      RND_W'(1): r = (a ^ 32'hc761c23c) ^ (a >> 19);
      RND_W'(2): r = (a + 32'h165667b1) + (a << 5);
      RND_W'(3): r = (a + 32'hd3a2646c) ^ (a << 9);
      RND_W'(4): r = (a + 32'hfd7046c5) + (a << 3);
      RND_W'(5): r = (a ^ 32'hb55a4f09) ^ (a >> 16);
      default:   r = a;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/cht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// ===== rtl/core/cht_front.sv =====
// Front end: takes one request, mixes its key one round a cycle, hands it on.
// Depends on cht_pkg.
module cht_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_value,
  output logic              push,
  output cht_pkg::cht_req_t push_req,
  input  logic              q_full
);
  import cht_pkg::*;

  logic             busy_r, busy_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [31:0]      a_r, a_nxt;
  logic [1:0]       func_r;
  logic [31:0]      key_r, val_r;
  logic             mixed;

  assign in_stall = busy_r;
  assign mixed    = (rnd_r > ROUND_LAST);
  assign push     = busy_r && mixed && !q_full;
  assign push_req = '{func: func_r, key: key_r, value: val_r, home: a_r[AW-1:0]};

  always_comb begin
    busy_nxt = busy_r;
    rnd_nxt  = rnd_r;
    a_nxt    = a_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        rnd_nxt  = '0;
        a_nxt    = in_key;
      end
    end else if (!mixed) begin
      a_nxt   = cht_round(a_r, rnd_r);
      rnd_nxt = rnd_r + RND_W'(1);
    end else if (push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
    end
    a_r <= a_nxt;
    if (!busy_r && in_valid) begin
      func_r <= in_func;
      key_r  <= in_key;
      val_r  <= in_value;
    end
  end
endmodule

// ===== rtl/core/cht_fifo.sv =====
// Two-entry queue of classified requests between front and back end.
// Depends on cht_pkg.
module cht_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cht_pkg::cht_req_t push_req,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output cht_pkg::cht_req_t head
);
  import cht_pkg::*;

  cht_req_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= push_req;
    end
  end
endmodule

// ===== rtl/core/cht_back.sv =====
// Back end: walks chains, probes and relinks slots over the slot memories.
// Depends on cht_pkg and cht_ram.
module cht_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  cht_pkg::cht_req_t         q_req,
  output logic                      pop,
  input  logic [cht_pkg::FILL_W-1:0] fill_limit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [31:0]               out_result_value,
  output logic [cht_pkg::NUM_W-1:0] out_slot_number,
  output logic [cht_pkg::NUM_W-1:0] out_entry_total,
  output cht_pkg::cht_stat_t        stat
);
  import cht_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_LRD = 4'd1,  S_LCHK = 4'd2,  S_DEC = 4'd3,
                         S_PROBE = 4'd4, S_HRD = 4'd5,  S_HCHK = 4'd6,  S_HLINK = 4'd7,
                         S_FHASH = 4'd8, S_RRD = 4'd9,  S_RCHK = 4'd10, S_SETH = 4'd11,
                         S_DRD = 4'd12,  S_DCHK = 4'd13, S_DONE = 4'd14;
  localparam logic [AW-1:0] WALK_END = AW'(SLOTS - 1);

  logic [3:0]       st_r, st_nxt;
  logic [SLOTS-1:0] used_r, used_nxt, home_r, home_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [31:0]      key_r, key_nxt, val_r, val_nxt, hdata_r, hdata_nxt, a_r, a_nxt;
  logic [AW-1:0]    h_r, h_nxt, cur_r, cur_nxt, prev_r, prev_nxt, pos_r, pos_nxt;
  logic [AW-1:0]    f_r, f_nxt, walk_r, walk_nxt, where_r, where_nxt, raddr_q;
  logic [LW-1:0]    pnext_r, pnext_nxt;
  logic             hit_r, hit_nxt, where_ok_r, where_ok_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      rv_r, rv_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             ovld_r;

  logic          key_we, data_we, next_we;
  logic [AW-1:0] key_wa, data_wa, next_wa, raddr;
  logic [31:0]   key_wd, data_wd, rd_key, rd_data, mixed;
  logic [LW-1:0] next_wd, rd_next, nxt_eff;
  logic [CMP_W-1:0] lim;
  logic          at_limit;

  cht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(raddr), .rdata(rd_key));
  cht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_data (
    .clk, .we(data_we), .waddr(data_wa), .wdata(data_wd), .raddr(raddr), .rdata(rd_data));
  cht_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(raddr), .rdata(rd_next));

  // a free slot always links nowhere, so mask stale link data by the used bit
  assign nxt_eff  = used_r[raddr_q] ? rd_next : NO_LINK;
  assign lim      = (CMP_W'(fill_limit) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(fill_limit);
  assign at_limit = (CMP_W'(count_r) >= lim);
  assign mixed    = cht_round(a_r, rnd_r);

  assign out_valid = ovld_r;
  assign stat      = '{idle: (st_r == S_IDLE), count: count_r};

  always_comb begin
    st_nxt = st_r;   used_nxt = used_r; home_nxt = home_r; count_nxt = count_r;
    func_nxt = func_r; key_nxt = key_r; val_nxt = val_r; hdata_nxt = hdata_r; a_nxt = a_r;
    h_nxt = h_r; cur_nxt = cur_r; prev_nxt = prev_r; pos_nxt = pos_r; f_nxt = f_r;
    walk_nxt = walk_r; where_nxt = where_r; pnext_nxt = pnext_r; hit_nxt = hit_r;
    where_ok_nxt = where_ok_r; status_nxt = status_r; rv_nxt = rv_r; rnd_nxt = rnd_r;
    pop = 1'b0;
    raddr = cur_r;
    key_we = 1'b0;  key_wa = f_r;  key_wd = key_r;
    data_we = 1'b0; data_wa = f_r; data_wd = val_r;
    next_we = 1'b0; next_wa = f_r; next_wd = nxt_eff;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          func_nxt = q_req.func; key_nxt = q_req.key; val_nxt = q_req.value;
          h_nxt = q_req.home; cur_nxt = q_req.home; walk_nxt = '0; hit_nxt = 1'b0;
          status_nxt = ST_MISS; rv_nxt = q_req.value; where_ok_nxt = 1'b0;
          if (q_req.func != FN_GET && q_req.func != FN_SET && q_req.func != FN_DEL) begin
            st_nxt = S_DONE;
          end else if (used_r[q_req.home] && home_r[q_req.home]) begin
            st_nxt = S_LRD;
          end else begin
            st_nxt = S_DEC;
          end
        end
      end
      S_LRD: st_nxt = S_LCHK;
      S_LCHK: begin
        if (rd_key == key_r) begin
          hit_nxt = 1'b1; pos_nxt = cur_r; hdata_nxt = rd_data; pnext_nxt = nxt_eff;
          st_nxt = S_DEC;
        end else if (nxt_eff[LW-1] || walk_r == WALK_END) begin
          st_nxt = S_DEC;
        end else begin
          prev_nxt = cur_r; cur_nxt = nxt_eff[AW-1:0]; walk_nxt = walk_r + AW'(1);
          st_nxt = S_LRD;
        end
      end
      S_DEC: begin
        st_nxt = S_DONE;
        unique case (func_r)
          FN_GET: begin
            if (hit_r) begin
              status_nxt = ST_HIT; rv_nxt = hdata_r; where_nxt = pos_r; where_ok_nxt = 1'b1;
            end
          end
          FN_SET: begin
            if (hit_r) begin
              data_we = 1'b1; data_wa = pos_r;
              status_nxt = ST_HIT; where_nxt = pos_r; where_ok_nxt = 1'b1;
            end else if (at_limit) begin
              status_nxt = ST_FULL;
            end else if (!used_r[h_r]) begin
              st_nxt = S_SETH;
            end else begin
              f_nxt = h_r + AW'(1); walk_nxt = '0; st_nxt = S_PROBE;
            end
          end
          FN_DEL: begin
            if (hit_r) begin
              status_nxt = ST_HIT; where_nxt = pos_r; where_ok_nxt = 1'b1;
              if (pos_r == h_r && !pnext_r[LW-1] && used_r[pnext_r[AW-1:0]]) begin
                st_nxt = S_DRD;
              end else begin
                if (pos_r != h_r) begin
                  next_we = 1'b1; next_wa = prev_r; next_wd = pnext_r;
                end
                used_nxt[pos_r] = 1'b0; home_nxt[pos_r] = 1'b0;
                if (count_r != '0) count_nxt = count_r - CNT_W'(1);
              end
            end
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_PROBE: begin
        if (!used_r[f_r]) begin
          st_nxt = S_HRD;
        end else if (walk_r == WALK_END) begin
          status_nxt = ST_FULL; st_nxt = S_DONE;
        end else begin
          f_nxt = f_r + AW'(1); walk_nxt = walk_r + AW'(1);
        end
      end
      S_HRD: begin
        raddr = h_r; st_nxt = S_HCHK;
      end
      S_HCHK: begin
        next_we = 1'b1; key_we = 1'b1; data_we = 1'b1;
        used_nxt[f_r] = 1'b1; home_nxt[f_r] = 1'b0;
        if (home_r[h_r]) begin
          count_nxt = count_r + CNT_W'(1);
          status_nxt = ST_INS; where_nxt = f_r; where_ok_nxt = 1'b1;
          st_nxt = S_HLINK;
        end else begin
          // move the foreign occupant out, then find its parent
          key_wd = rd_key; data_wd = rd_data;
          a_nxt = rd_key; rnd_nxt = '0;
          st_nxt = S_FHASH;
        end
      end
      S_HLINK: begin
        next_we = 1'b1; next_wa = h_r; next_wd = LW'(f_r);
        st_nxt = S_DONE;
      end
      S_FHASH: begin
        a_nxt = mixed; rnd_nxt = rnd_r + RND_W'(1);
        if (rnd_r == ROUND_LAST) begin
          cur_nxt = mixed[AW-1:0]; walk_nxt = '0; st_nxt = S_RRD;
        end
      end
      S_RRD: st_nxt = S_RCHK;
      S_RCHK: begin
        if (nxt_eff == LW'(h_r)) begin
          next_we = 1'b1; next_wa = cur_r; next_wd = LW'(f_r);
          st_nxt = S_SETH;
        end else if (nxt_eff[LW-1] || walk_r == WALK_END) begin
          st_nxt = S_SETH;
        end else begin
          cur_nxt = nxt_eff[AW-1:0]; walk_nxt = walk_r + AW'(1);
          st_nxt = S_RRD;
        end
      end
      S_SETH: begin
        key_we = 1'b1; key_wa = h_r; data_we = 1'b1; data_wa = h_r;
        next_we = 1'b1; next_wa = h_r; next_wd = NO_LINK;
        used_nxt[h_r] = 1'b1; home_nxt[h_r] = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        status_nxt = ST_INS; where_nxt = h_r; where_ok_nxt = 1'b1;
        st_nxt = S_DONE;
      end
      S_DRD: begin
        raddr = pnext_r[AW-1:0]; st_nxt = S_DCHK;
      end
      S_DCHK: begin
        // pull the successor into the head slot
        key_we = 1'b1; key_wa = h_r; key_wd = rd_key;
        data_we = 1'b1; data_wa = h_r; data_wd = rd_data;
        next_we = 1'b1; next_wa = h_r; next_wd = nxt_eff;
        used_nxt[pnext_r[AW-1:0]] = 1'b0; home_nxt[pnext_r[AW-1:0]] = 1'b0;
        if (count_r != '0) count_nxt = count_r - CNT_W'(1);
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovld_r || !out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      used_r  <= '0;
      home_r  <= '0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      used_r  <= used_nxt;
      home_r  <= home_nxt;
      count_r <= count_nxt;
      if (st_r == S_DONE && (!ovld_r || !out_stall)) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
    raddr_q <= raddr;
    func_r <= func_nxt; key_r <= key_nxt; val_r <= val_nxt; hdata_r <= hdata_nxt;
    a_r <= a_nxt; h_r <= h_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt; pos_r <= pos_nxt;
    f_r <= f_nxt; walk_r <= walk_nxt; where_r <= where_nxt; pnext_r <= pnext_nxt;
    hit_r <= hit_nxt; where_ok_r <= where_ok_nxt; status_r <= status_nxt; rv_r <= rv_nxt;
    rnd_r <= rnd_nxt;
    if (st_r == S_DONE && (!ovld_r || !out_stall)) begin
      out_status       <= status_r;
      out_result_value <= rv_r;
      out_slot_number  <= where_ok_r ? NUM_W'(where_r) + NUM_W'(1) : '0;
      out_entry_total  <= NUM_W'(count_r);
    end
  end
endmodule

// ===== rtl/core/coalesced_hash_table.sv =====
// Top level of the coalesced hash table: fill limit register, front, queue, back.
// Depends on cht_pkg, cht_front, cht_fifo, cht_back.
//
//   port group | dir | handshake         | contents
//   in_        | in  | in_valid/in_stall | func, key, value
//   out_       | out | out_valid/out_stall| status, result_value, slot_number, entry_total
//   cfg_       | in  | cfg_valid/cfg_ready| fill limit
//
// Front mixes the key through every round of cht_round, then hands the request on
// when the queue is not full. Back reads and checks each chain step, probes slots
// in turn for a free one, then places a probed slot and links it, or moves a foreign
// occupant out and walks its parent's chain to relink it; one request at a time.
// Reset (rst_n low, synchronous) empties the table at once via per-slot used bits.
// A stalled result holds in the output register; queued requests wait behind it.
module coalesced_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [31:0]                in_key,
  input  logic [31:0]                in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_result_value,
  output logic [cht_pkg::NUM_W-1:0]  out_slot_number,
  output logic [cht_pkg::NUM_W-1:0]  out_entry_total,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cht_pkg::FILL_W-1:0] cfg_data
);
  import cht_pkg::*;

  logic [FILL_W-1:0] fill_r;
  logic              push, q_full, pop, q_valid;
  cht_req_t          push_req, q_req;
  cht_stat_t         stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fill_r <= cfg_data;
    end
  end

  cht_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_key, .in_value,
    .push, .push_req, .q_full);

  cht_fifo u_fifo (
    .clk, .rst_n, .push, .push_req, .full(q_full), .pop, .not_empty(q_valid), .head(q_req));

  cht_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .pop, .fill_limit(fill_r),
    .out_valid, .out_stall, .out_status, .out_result_value, .out_slot_number,
    .out_entry_total, .stat);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(SLOTS)) else $error("entry count beyond slot count");
  a_ins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INS) |-> (out_entry_total != '0 && out_slot_number != '0))
    else $error("insert reported with empty table");
  a_full_noslot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_MISS)) |-> out_slot_number == '0)
    else $error("refused or missed request reports a slot");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (stat.idle && q_valid)) else $error("queue popped while back end busy");
`endif
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for coalesced_hash_table: directed table, then random phases.
// Depends on cht_pkg and the RTL; holds its own slot-level predictor of the table.
module tb;
  import cht_pkg::*;

  localparam logic [1:0]  FN_SPARE  = 2'd3;
  localparam int unsigned NIL       = 32'hFFFF_FFFF;
  localparam int          POOL_N    = 96;
  localparam int          PHASE_N   = 200;
  localparam int          WDOG_MAX  = 5000;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      rvalue;
    logic [NUM_W-1:0] slot;
    logic [NUM_W-1:0] total;
  } outcome_t;

  typedef struct {
    logic [1:0]  fn;
    int          sel;    // 0: literal key, else colliding key sel-1
    logic [31:0] key;
    logic [31:0] val;
    bit          typed;
    logic [1:0]  st;
    logic [31:0] rv;
    int          tot;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func = FN_GET;
  logic [31:0]          in_key = '0;
  logic [31:0]          in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [31:0]          out_result_value;
  logic [NUM_W-1:0]     out_slot_number;
  logic [NUM_W-1:0]     out_entry_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [FILL_W-1:0]    cfg_data = FILL_RESET;

  // predictor state
  bit          t_used [SLOTS];
  bit          t_home [SLOTS];
  logic [31:0] t_key  [SLOTS];
  logic [31:0] t_data [SLOTS];
  int unsigned t_next [SLOTS];
  int unsigned t_count;
  int unsigned t_limit;

  outcome_t    awaited_results[$];
  logic [31:0] key_pool[POOL_N];
  logic [31:0] twins[4];
  int          mismatches = 0;
  bit          quiet = 1'b0;

  coalesced_hash_table dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned home_slot(logic [31:0] a);
    a = (a + 32'h7ed55d16) + (a << 12);
    a = (a ^ 32'hc761c23c) ^ (a >> 19);
    a = (a + 32'h165667b1) + (a << 5);
    a = (a + 32'hd3a2646c) ^ (a << 9);
    a = (a + 32'hfd7046c5) + (a << 3);
    a = (a ^ 32'hb55a4f09) ^ (a >> 16);
    return a % SLOTS;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < SLOTS; i++) begin
      t_used[i] = 0; t_home[i] = 0; t_next[i] = NIL;
      t_key[i] = '0; t_data[i] = '0;
    end
    t_count = 0;
    t_limit = FILL_RESET;
  endfunction

  function automatic int unsigned chain_find(logic [31:0] k, int unsigned h);
    int unsigned cur;
    cur = h;
    if (!t_used[h] || !t_home[h]) return SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (t_key[cur] == k) return cur;
      if (t_next[cur] >= SLOTS) return SLOTS;
      cur = t_next[cur];
    end
    return SLOTS;
  endfunction

  function automatic int unsigned free_after(int unsigned h);
    for (int i = 1; i <= SLOTS; i++)
      if (!t_used[(h + i) % SLOTS]) return (h + i) % SLOTS;
    return SLOTS;
  endfunction

  function automatic void redirect(int unsigned start, int unsigned target,
                                   int unsigned repl);
    int unsigned cur;
    cur = start;
    for (int n = 0; n < SLOTS; n++) begin
      if (t_next[cur] == target) begin
        t_next[cur] = repl;
        return;
      end
      if (t_next[cur] >= SLOTS) return;
      cur = t_next[cur];
    end
  endfunction

  function automatic void drop_slot(int unsigned s);
    t_used[s] = 0; t_home[s] = 0; t_next[s] = NIL;
  endfunction

  function automatic outcome_t table_apply(logic [1:0] fn, logic [31:0] k, logic [31:0] v);
    int unsigned h, pos, where, lim, f, nx;
    outcome_t r;
    h = home_slot(k);
    pos = chain_find(k, h);
    r.status = ST_MISS; r.rvalue = v; where = SLOTS;
    if (fn == FN_GET) begin
      if (pos != SLOTS) begin
        r.status = ST_HIT; r.rvalue = t_data[pos]; where = pos;
      end
    end else if (fn == FN_SET) begin
      if (pos != SLOTS) begin
        t_data[pos] = v; r.status = ST_HIT; where = pos;
      end else begin
        lim = (t_limit > SLOTS) ? SLOTS : t_limit;
        f = SLOTS;
        if (t_used[h] && t_count < lim) f = free_after(h);
        if (t_count >= lim || (t_used[h] && f == SLOTS)) begin
          r.status = ST_FULL;
        end else begin
          if (!t_used[h]) begin
            where = h;
          end else if (t_home[h]) begin
            t_used[f] = 1; t_home[f] = 0;
            t_next[f] = t_next[h]; t_next[h] = f;
            where = f;
          end else begin
            // evict the foreign occupant, then claim the home slot
            t_used[f] = 1; t_home[f] = 0;
            t_key[f] = t_key[h]; t_data[f] = t_data[h]; t_next[f] = t_next[h];
            redirect(home_slot(t_key[h]), h, f);
            where = h;
          end
          if (where == h) begin
            t_used[h] = 1; t_home[h] = 1; t_next[h] = NIL;
          end
          t_key[where] = k; t_data[where] = v;
          t_count++;
          r.status = ST_INS;
        end
      end
    end else if (fn == FN_DEL) begin
      if (pos != SLOTS) begin
        if (pos == h) begin
          nx = t_next[h];
          if (nx < SLOTS && t_used[nx]) begin
            t_key[h] = t_key[nx]; t_data[h] = t_data[nx]; t_next[h] = t_next[nx];
            drop_slot(nx);
          end else begin
            drop_slot(h);
          end
        end else begin
          redirect(h, pos, t_next[pos]);
          drop_slot(pos);
        end
        if (t_count > 0) t_count--;
        r.status = ST_HIT; where = pos;
      end
    end
    r.slot = (where == SLOTS) ? '0 : NUM_W'(where + 1);
    r.total = NUM_W'(t_count);
    return r;
  endfunction

  // drive one request and hold it until taken
  task automatic send_request(logic [1:0] fn, logic [31:0] k, logic [31:0] v,
                              bit typed, logic [1:0] st, logic [31:0] rv, int tot);
    outcome_t e;
    if (!quiet && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b1; in_func = fn; in_key = k; in_value = v;
    do @(posedge clk); while (in_stall);
    e = table_apply(fn, k, v);
    if (typed) begin
      e.status = st; e.rvalue = rv; e.total = NUM_W'(tot);
    end
    awaited_results.push_back(e);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [FILL_W-1:0] lim);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1; cfg_data = lim;
    do @(posedge clk); while (!cfg_ready);
    t_limit = lim;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver stall bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) burst = $urandom_range(20, 60);
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 15);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_result_value, out_slot_number, out_entry_total};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %h slot %0d total %0d",
                   got.status, got.rvalue, got.slot, got.total);
      end else begin
        e = awaited_results.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                     e.status, e.rvalue, e.slot, e.total,
                     got.status, got.rvalue, got.slot, got.total);
        end
      end
    end
  end

  // watchdog on handshake progress
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= WDOG_MAX) begin
        $display("coalesced_hash_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[16];
    logic [FILL_W-1:0] limits[6];
    logic [1:0] fn;
    logic [31:0] k;
    int n, w_set, w_del;
    rows = '{
      '{FN_GET,   0, 32'h0,        32'h7FFF_FFFF, 1, ST_MISS, 32'h7FFF_FFFF, 0},
      '{FN_SPARE, 0, 32'hFFFF_FFFF, 32'h8000_0000, 1, ST_MISS, 32'h8000_0000, 0},
      '{FN_DEL,   0, 32'hFFFF_FFFF, 32'h1,        1, ST_MISS, 32'h1,        0},
      '{FN_SET,   0, 32'hFFFF_FFFF, 32'h8000_0000, 1, ST_INS,  32'h8000_0000, 1},
      '{FN_SET,   0, 32'h0,        32'h7FFF_FFFF, 1, ST_INS,  32'h7FFF_FFFF, 2},
      '{FN_GET,   0, 32'hFFFF_FFFF, 32'h5,        1, ST_HIT,  32'h8000_0000, 2},
      '{FN_SET,   0, 32'h0,        32'hFFFF_FFFF, 1, ST_HIT,  32'hFFFF_FFFF, 2},
      '{FN_DEL,   0, 32'h0,        32'h0,        1, ST_HIT,  32'h0,        1},
      '{FN_SET,   1, 32'h0,        32'h11,       0, 0, 0, 0},
      '{FN_SET,   2, 32'h0,        32'h22,       0, 0, 0, 0},
      '{FN_SET,   3, 32'h0,        32'h33,       0, 0, 0, 0},
      '{FN_GET,   3, 32'h0,        32'h0,        0, 0, 0, 0},
      '{FN_DEL,   1, 32'h0,        32'h0,        0, 0, 0, 0},
      '{FN_SET,   4, 32'h0,        32'h44,       0, 0, 0, 0},
      '{FN_DEL,   3, 32'h0,        32'h0,        0, 0, 0, 0},
      '{FN_GET,   4, 32'h0,        32'h9,        0, 0, 0, 0}
    };
    limits = '{FILL_RESET, 7'd1, 7'd64, 7'd127, 7'd0, 7'd48};
    limits[5] = FILL_W'($urandom_range(1, 64));
    // keys sharing one home slot, for chain heads, links and successor pull-in
    n = 0;
    twins[0] = $urandom;
    for (logic [31:0] c = twins[0] + 1; n < 3; c++)
      if (home_slot(c) == home_slot(twins[0])) begin
        n++;
        twins[n] = c;
      end
    foreach (key_pool[i]) key_pool[i] = $urandom;
    table_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i])
      send_request(rows[i].fn, (rows[i].sel == 0) ? rows[i].key : twins[rows[i].sel - 1],
                   rows[i].val, rows[i].typed, rows[i].st, rows[i].rv, rows[i].tot);

    foreach (limits[p]) begin
      if (p != 0) write_limit(limits[p]);
      quiet = (p == 5);
      w_set = $urandom_range(35, 70);
      w_del = $urandom_range(10, 35);
      for (int i = 0; i < PHASE_N; i++) begin
        n = $urandom_range(0, 99);
        if (n < w_set) fn = FN_SET;
        else if (n < w_set + w_del) fn = FN_DEL;
        else if (n < 97) fn = FN_GET;
        else fn = FN_SPARE;
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                          : $urandom;
        send_request(fn, k, $urandom, 0, 0, 0, 0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("coalesced_hash_table verification clean");
    else
      $display("coalesced_hash_table verification failed");
    $finish;
  end

endmodule
